// ===== sv/bgra2rgba_pkg.sv =====
package bgra2rgba_pkg;

   localparam int unsigned CHAN_W      = 8;
   localparam int unsigned RECIP_W     = 24;
   localparam int unsigned PROD_W      = 32;
   localparam int unsigned FRAC_W      = 16;
   localparam int unsigned RECIP_DEPTH = 256;

   localparam logic [PROD_W-1:0] FULL_SCALE = 32'd16711680;
   localparam logic [PROD_W-1:0] ROUND_HALF = 32'h0000_8000;
   localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'hFF;
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

   // last member sits in the lowest bits
   typedef struct packed {
      logic [CHAN_W-1:0] alpha;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } bgra_type;

   typedef struct packed {
      logic [CHAN_W-1:0] alpha;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } rgba_type;

endpackage

// ===== sv/bgra_premul_to_rgba_straight.sv =====
// Converts a stream of premultiplied BGRA pixels into straight-alpha RGBA pixels, one pixel
// per clock cycle sustained while rsp_tready is high, through two registers in turn: the
// first register holds the pixel together with the reciprocal of its alpha, read from a
// constant 256-entry table, and the second holds the finished pixel after three parallel
// 8x24 multiplies with rounding and saturation. Opaque pixels are only reordered and
// transparent ones come out as all zero. rsp_tuser carries a flag that is set once any pixel
// of the current image had alpha below 255; it is final on the result marked by rsp_tlast
// and starts cleared on the next image. req_tready follows rsp_tready combinationally.
module bgra_premul_to_rgba_straight (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // blue_in, green_in, red_in, alpha_in
   input  logic        req_tlast,   // image_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // red_out, green_out, blue_out, alpha_out
   output logic        rsp_tuser,   // image_translucent
   output logic        rsp_tlast    // image_last
);

   localparam int unsigned CW = bgra2rgba_pkg::CHAN_W;
   localparam int unsigned RW = bgra2rgba_pkg::RECIP_W;
   localparam int unsigned PW = bgra2rgba_pkg::PROD_W;
   localparam int unsigned FW = bgra2rgba_pkg::FRAC_W;

   function automatic logic [CW-1:0] unpremul(input logic [CW-1:0] c,
                                              input logic [CW-1:0] a,
                                              input logic [RW-1:0] inv);
      logic [PW-1:0] prod;
      logic [PW-FW-1:0] quo;
      prod = PW'(c) * PW'(inv) + bgra2rgba_pkg::ROUND_HALF;
      quo  = prod[PW-1:FW];
      if (c > a) begin
         unpremul = bgra2rgba_pkg::CHAN_MAX;
      end else if (quo > (PW-FW)'(bgra2rgba_pkg::CHAN_MAX)) begin
         unpremul = bgra2rgba_pkg::CHAN_MAX;
      end else begin
         unpremul = quo[CW-1:0];
      end
   endfunction

   // reciprocal table, round((255 << 16) / a)
   logic [RW-1:0] recip_tab [bgra2rgba_pkg::RECIP_DEPTH];

   assign recip_tab[0] = '0;
   for (genvar gi = 1; gi < bgra2rgba_pkg::RECIP_DEPTH; gi++) begin : g_recip
      localparam logic [PW-1:0] RECIP = (bgra2rgba_pkg::FULL_SCALE + gi / 2) / gi;
      assign recip_tab[gi] = RECIP[RW-1:0];
   end

   bgra2rgba_pkg::bgra_type req_pix;
   bgra2rgba_pkg::bgra_type pix_ff;
   logic [RW-1:0]           inv_ff;
   logic                    last_ff;
   logic                    s1_vld_ff, s1_vld_in;

   bgra2rgba_pkg::rgba_type out_ff, out_in;
   logic                    out_last_ff;
   logic                    out_trans_ff, out_trans_in;
   logic                    out_vld_ff, out_vld_in;
   logic                    flag_ff, flag_in;

   logic out_free;
   logic s1_move;
   logic req_take;

   assign req_pix  = bgra2rgba_pkg::bgra_type'(req_tdata);
   assign out_free = !out_vld_ff || rsp_tready;
   assign s1_move  = s1_vld_ff && out_free;
   assign req_tready = !s1_vld_ff || s1_move;
   assign req_take = req_tvalid && req_tready;

   always_comb begin
      s1_vld_in  = req_take ? 1'b1 : (s1_move ? 1'b0 : s1_vld_ff);
      out_vld_in = s1_move ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);
   end

   always_comb begin
      out_trans_in = flag_ff || (pix_ff.alpha != bgra2rgba_pkg::ALPHA_OPAQUE);
      flag_in      = last_ff ? 1'b0 : out_trans_in;
      if (pix_ff.alpha == bgra2rgba_pkg::ALPHA_OPAQUE) begin
         out_in.red   = pix_ff.red;
         out_in.green = pix_ff.green;
         out_in.blue  = pix_ff.blue;
         out_in.alpha = pix_ff.alpha;
      end else if (pix_ff.alpha == bgra2rgba_pkg::ALPHA_CLEAR) begin
         out_in = '0;
      end else begin
         out_in.red   = unpremul(pix_ff.red,   pix_ff.alpha, inv_ff);
         out_in.green = unpremul(pix_ff.green, pix_ff.alpha, inv_ff);
         out_in.blue  = unpremul(pix_ff.blue,  pix_ff.alpha, inv_ff);
         out_in.alpha = pix_ff.alpha;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         flag_ff    <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
         if (s1_move) begin
            flag_ff <= flag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         pix_ff  <= req_pix;
         inv_ff  <= recip_tab[req_pix.alpha];
         last_ff <= req_tlast;
      end
      if (s1_move) begin
         out_ff       <= out_in;
         out_trans_ff <= out_trans_in;
         out_last_ff  <= last_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = 32'(out_ff);
   assign rsp_tuser  = out_trans_ff;
   assign rsp_tlast  = out_last_ff;

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (out_ff.alpha == bgra2rgba_pkg::ALPHA_CLEAR))
         |-> (out_ff == '0) && rsp_tuser)
      else $error("transparent pixel not zero or flag not set");

   a_trans_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (out_ff.alpha != bgra2rgba_pkg::ALPHA_OPAQUE)) |-> rsp_tuser)
      else $error("translucent pixel without flag");

   a_flag_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> !flag_ff)
      else $error("flag not cleared after last pixel");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_vld_ff && out_vld_ff && !rsp_tready))
      else $error("request stalled with room in pipeline");

endmodule

// ===== bench/unpremul_checker.sv =====
`timescale 1ns / 100ps

module unpremul_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // blue_in, green_in, red_in, alpha_in
   input  logic        req_tlast,   // image_end
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // red_out, green_out, blue_out, alpha_out
   input  logic        rsp_tuser,   // image_translucent
   input  logic        rsp_tlast,   // image_last
   output int          errors,
   output int          outstanding
);

   typedef struct {
      bgra2rgba_pkg::rgba_type pixel;
      logic                    translucent;
      logic                    last;
   } straight_pixel_type;

   straight_pixel_type              expected_pixels[$];
   logic [bgra2rgba_pkg::RECIP_W-1:0] recip_lut [bgra2rgba_pkg::RECIP_DEPTH];
   logic                            translucent_seen;
   bgra2rgba_pkg::bgra_type         req_pixel;
   bgra2rgba_pkg::rgba_type         rsp_pixel;
   straight_pixel_type              want;

   initial begin
      recip_lut[0] = '0;
      for (int a = 1; a < bgra2rgba_pkg::RECIP_DEPTH; a++) begin
         recip_lut[a] = bgra2rgba_pkg::RECIP_W'((bgra2rgba_pkg::FULL_SCALE + 32'(a / 2))
                                                / 32'(a));
      end
   end

   function automatic logic [bgra2rgba_pkg::CHAN_W-1:0] straighten(
         logic [bgra2rgba_pkg::CHAN_W-1:0] c,
         logic [bgra2rgba_pkg::CHAN_W-1:0] a);
      logic [bgra2rgba_pkg::PROD_W-1:0] scaled;
      if (c > a) begin
         return bgra2rgba_pkg::CHAN_MAX;
      end
      scaled = (bgra2rgba_pkg::PROD_W'(c) * bgra2rgba_pkg::PROD_W'(recip_lut[a])
                + bgra2rgba_pkg::ROUND_HALF) >> bgra2rgba_pkg::FRAC_W;
      return (scaled > bgra2rgba_pkg::PROD_W'(bgra2rgba_pkg::CHAN_MAX)) ?
             bgra2rgba_pkg::CHAN_MAX : scaled[bgra2rgba_pkg::CHAN_W-1:0];
   endfunction

   function automatic straight_pixel_type unpremultiply(bgra2rgba_pkg::bgra_type px,
                                                        logic last);
      straight_pixel_type res;
      if (px.alpha == bgra2rgba_pkg::ALPHA_OPAQUE) begin
         res.pixel.red   = px.red;
         res.pixel.green = px.green;
         res.pixel.blue  = px.blue;
         res.pixel.alpha = bgra2rgba_pkg::ALPHA_OPAQUE;
      end else if (px.alpha == bgra2rgba_pkg::ALPHA_CLEAR) begin
         res.pixel = '0;
      end else begin
         res.pixel.red   = straighten(px.red, px.alpha);
         res.pixel.green = straighten(px.green, px.alpha);
         res.pixel.blue  = straighten(px.blue, px.alpha);
         res.pixel.alpha = px.alpha;
      end
      res.translucent = translucent_seen | (px.alpha != bgra2rgba_pkg::ALPHA_OPAQUE);
      res.last = last;
      translucent_seen = last ? 1'b0 : res.translucent;
      return res;
   endfunction

   task automatic check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $error("%s expected %0d got %0d", name, exp_val, act_val);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         translucent_seen = 1'b0;
         expected_pixels.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_pixel = rsp_tdata;
            if (expected_pixels.size() == 0) begin
               $error("result with no pending request, tdata %h", rsp_tdata);
               errors++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("red_out", want.pixel.red, rsp_pixel.red);
               check_field("green_out", want.pixel.green, rsp_pixel.green);
               check_field("blue_out", want.pixel.blue, rsp_pixel.blue);
               check_field("alpha_out", want.pixel.alpha, rsp_pixel.alpha);
               check_field("image_translucent", want.translucent, rsp_tuser);
               check_field("image_last", want.last, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) begin
            req_pixel = req_tdata;
            expected_pixels.push_back(unpremultiply(req_pixel, req_tlast));
         end
      end
      outstanding <= expected_pixels.size();
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int STALL_LIMIT   = 2000;
   localparam int PHASE_PIXELS  = 600;
   localparam int HOLD_CYCLES   = 80;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // blue_in, green_in, red_in, alpha_in
   logic        req_tlast;   // image_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // red_out, green_out, blue_out, alpha_out
   logic        rsp_tuser;   // image_translucent
   logic        rsp_tlast;   // image_last

   int errors;
   int outstanding;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_req;
   int hold_done;
   int hold_left;
   int idle_cycles;
   int pixels_sent;
   int images_sent;
   int opaque_sent;
   int clear_sent;
   int partial_sent;
   int phase_start;

   bgra_premul_to_rgba_straight u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   unpremul_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .errors      (errors),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver side, with an occasional long hold-off
   initial begin
      rsp_tready = 1'b0;
      hold_left = 0;
      hold_done = 0;
      forever begin
         @(negedge clock);
         if (hold_done != hold_req) begin
            hold_done = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[bgra_premul_to_rgba_straight] ERROR");
            $finish;
         end
      end
   end

   function automatic bgra2rgba_pkg::bgra_type pix(int b, int g, int r, int a);
      bgra2rgba_pkg::bgra_type px;
      px.blue  = b[7:0];
      px.green = g[7:0];
      px.red   = r[7:0];
      px.alpha = a[7:0];
      return px;
   endfunction

   function automatic bgra2rgba_pkg::bgra_type random_pixel();
      int kind;
      int a;
      kind = $urandom_range(99);
      if (kind < 30) begin
         return pix($urandom_range(255), $urandom_range(255), $urandom_range(255), 255);
      end else if (kind < 40) begin
         return pix($urandom_range(255), $urandom_range(255), $urandom_range(255), 0);
      end else if (kind < 90) begin
         a = $urandom_range(1, 254);
         return pix($urandom_range(a), $urandom_range(a), $urandom_range(a), a);
      end
      return pix($urandom_range(255), $urandom_range(255), $urandom_range(255),
                 $urandom_range(255));
   endfunction

   task automatic send_pixel(bgra2rgba_pkg::bgra_type px, logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
      if (last) begin
         images_sent++;
      end
      if (px.alpha == bgra2rgba_pkg::ALPHA_OPAQUE) begin
         opaque_sent++;
      end else if (px.alpha == bgra2rgba_pkg::ALPHA_CLEAR) begin
         clear_sent++;
      end else begin
         partial_sent++;
      end
   endtask

   task automatic send_image(int len);
      for (int i = 0; i < len; i++) begin
         send_pixel(random_pixel(), i == len - 1);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      hold_req = 0;
      send_idle_pct = 21;
      recv_idle_pct = 57;
      pixels_sent = 0;
      images_sent = 0;
      opaque_sent = 0;
      clear_sent = 0;
      partial_sent = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // opaque-only image keeps the flag low
      send_pixel(pix(8'h12, 8'h34, 8'h56, 255), 1'b0);
      send_pixel(pix(8'hFF, 8'hFF, 8'hFF, 255), 1'b0);
      send_pixel(pix(8'h00, 8'h00, 8'h00, 255), 1'b1);
      // transparent pixels, then flag cleared on the next image
      send_pixel(pix(8'hFF, 8'hFF, 8'hFF, 0), 1'b0);
      send_pixel(pix(8'hAA, 8'h55, 8'h01, 0), 1'b1);
      send_pixel(pix(8'h01, 8'h02, 8'h03, 255), 1'b1);
      // colour above alpha and edge alphas
      send_pixel(pix(8'h00, 8'h01, 8'h02, 1), 1'b0);
      send_pixel(pix(8'hFF, 8'h80, 8'h01, 1), 1'b0);
      send_pixel(pix(8'h01, 8'h02, 8'h03, 2), 1'b0);
      send_pixel(pix(128, 64, 0, 128), 1'b0);
      send_pixel(pix(200, 129, 127, 128), 1'b0);
      send_pixel(pix(8'h7F, 8'h80, 8'h81, 128), 1'b0);
      send_pixel(pix(254, 253, 255, 254), 1'b0);
      send_pixel(pix(1, 0, 127, 254), 1'b0);
      send_pixel(pix(8'h55, 8'hAA, 8'h0F, 8'hF0), 1'b0);
      send_pixel(pix(8'hF0, 8'hE0, 8'h10, 8'hFE), 1'b1);
      send_pixel(pix(8'hA5, 8'h5A, 8'hC3, 255), 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 57 : 0;
         recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 21 : 0;
         phase_start = pixels_sent;
         while (pixels_sent - phase_start < PHASE_PIXELS) begin
            if (phase == 2 && pixels_sent - phase_start >= 100 && hold_req == hold_done &&
                hold_left == 0 && pixels_sent - phase_start < 140) begin
               hold_req++;
            end
            send_image(($urandom_range(9) == 0) ? 1 : $urandom_range(2, 40));
         end
         if (phase == 1) begin
            drain();
         end
      end

      drain();
      repeat (4) @(posedge clock);
      $display("sent %0d pixels in %0d images: %0d opaque, %0d transparent, %0d partial",
               pixels_sent, images_sent, opaque_sent, clear_sent, partial_sent);
      $display("idle mixes 21/57, 57/21 and none, with one long result hold-off");
      if (errors == 0) begin
         $display("[bgra_premul_to_rgba_straight] OK");
      end else begin
         $display("[bgra_premul_to_rgba_straight] ERROR");
      end
      $finish;
   end

endmodule
